// ===== sv/mchrm_pkg.sv =====
// Shared types and constants for the multi-channel heartbeat and rate monitor.
// Used by mchrm_div and multi_channel_heartbeat_rate_monitor; no dependencies.
package mchrm_pkg;

   localparam int TOPICS = 16;
   localparam int IDX_W = $clog2(TOPICS);
   localparam int MAX_EVENTS = 32;
   localparam int CAP_W = 6;

   // 1e12 split into a low 32-bit part and a high 8-bit part.
   localparam logic [31:0] TERA_LO = 32'hD4A5_1000;
   localparam logic [7:0] TERA_HI = 8'hE8;

   typedef enum logic [1:0] {
      OP_MESSAGE     = 2'd0,
      OP_TICK        = 2'd1,
      OP_CONFIGURE   = 2'd2,
      OP_DECONFIGURE = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_ACCEPTED  = 3'd0,
      KIND_REJECTED  = 3'd1,
      KIND_DEAD      = 3'd2,
      KIND_RATE_LOW  = 3'd3,
      KIND_RATE_HIGH = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REPLAY,
      ST_SCAN,
      ST_MUL,
      ST_PROD,
      ST_DIV,
      ST_EVAL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic conf;
      logic hb;
      logic rate_on;
      logic seen;
      logic dead;
      logic low;
      logic high;
      logic pend;
      logic phigh;
   } flags_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  severity;
      logic [7:0]  channel;
      logic [63:0] origin;
      logic [63:0] event_time;
      logic [63:0] measured;
      logic [63:0] limit;
   } event_type;

   typedef struct packed {
      logic        start;
      logic [7:0]  dividend_hi;
      logic [63:0] dividend_lo;
      logic [63:0] divisor;
   } div_req_type;

endpackage

// ===== sv/multi_channel_heartbeat_rate_monitor.sv =====
// Per-channel heartbeat and rate watchdog. Message, deconfigure and configure beats are
// handled in idle; the configure answer appears in the cycle after the beat. A tick with
// nonzero capacity holds busy high while it walks the channels: a replay pass, one channel
// per cycle, then, unless a deferred event finds no room, a scan pass using the shared
// 64-step divider per ending window (skipped when the rate saturates), then a flush state;
// its final beat follows the flush. Results are strobed for one cycle and cannot be stalled.
// Synchronous reset clears the channel flags and sets the event capacity to 32; other per-channel stores start unknown.
module multi_channel_heartbeat_rate_monitor (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_opcode,
   input  logic [7:0]   req_channel,
   input  logic [63:0]  req_time_ns,
   input  logic         req_heartbeat_on,
   input  logic [63:0]  req_dead_timeout_ns,
   input  logic         req_rate_on,
   input  logic [63:0]  req_window_ns,
   input  logic [39:0]  req_low_limit_mhz,
   input  logic [39:0]  req_high_limit_mhz,
   input  logic [39:0]  req_hysteresis_mhz,
   input  logic [7:0]   req_severity,
   input  logic         csr_we,
   input  logic [5:0]   csr_wdata,
   output logic         rsp_valid,
   output logic [2:0]   rsp_kind,
   output logic [7:0]   rsp_event_severity,
   output logic [7:0]   rsp_event_channel,
   output logic [63:0]  rsp_origin_ns,
   output logic [63:0]  rsp_event_time_ns,
   output logic [63:0]  rsp_measured,
   output logic [63:0]  rsp_limit,
   output logic         rsp_last
);

   localparam int IW = mchrm_pkg::IDX_W;
   localparam int CW = mchrm_pkg::CAP_W;

   // Per-channel state. Only the flags are reset; every other store is written by a
   // configure, message or deferral before the flags allow it to be read.
   mchrm_pkg::flags_type flags_ff [mchrm_pkg::TOPICS];
   logic [63:0] lmt_mem  [mchrm_pkg::TOPICS];
   logic [63:0] ct_mem   [mchrm_pkg::TOPICS];
   logic [63:0] ws_mem   [mchrm_pkg::TOPICS];
   logic [31:0] cnt_mem  [mchrm_pkg::TOPICS];
   logic [63:0] to_mem   [mchrm_pkg::TOPICS];
   logic [63:0] wl_mem   [mchrm_pkg::TOPICS];
   logic [39:0] lo_mem   [mchrm_pkg::TOPICS];
   logic [39:0] hi_mem   [mchrm_pkg::TOPICS];
   logic [39:0] hy_mem   [mchrm_pkg::TOPICS];
   logic [7:0]  sev_mem  [mchrm_pkg::TOPICS];
   logic [63:0] dst_mem  [mchrm_pkg::TOPICS];
   logic [63:0] dtm_mem  [mchrm_pkg::TOPICS];
   logic [63:0] drt_mem  [mchrm_pkg::TOPICS];

   // Sequencer and datapath registers.
   mchrm_pkg::state_type state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] cap_ff, cap_in;
   logic [CW-1:0] csr_cap_ff;
   logic [63:0]   now_ff, now_in;
   logic [63:0]   elapsed_ff, elapsed_in;
   logic [63:0]   wstart_ff, wstart_in;
   logic [63:0]   rate_ff, rate_in;
   logic [63:0]   p0_ff, p0_in;
   logic [39:0]   p1_ff, p1_in;
   mchrm_pkg::event_type held_ff, held_in;
   logic          held_valid_ff, held_valid_in;
   mchrm_pkg::event_type out_ff, out_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_last_ff, out_last_in;

   // Shared divider.
   mchrm_pkg::div_req_type div_req;
   logic        div_done;
   logic [63:0] div_q;

   // One address serves every read and write: the request's channel when idle,
   // the walking channel index otherwise.
   logic [IW-1:0] rd_idx;
   logic [7:0]    req_idx_full;
   mchrm_pkg::flags_type f, g;
   logic [63:0] lmt_rd, ct_rd, ws_rd, to_rd, wl_rd, dst_rd, dtm_rd, drt_rd;
   logic [31:0] cnt_rd;
   logic [39:0] lo_rd, hi_rd, hy_rd;
   logic [7:0]  sev_rd;

   // Write controls.
   logic                 flags_we;
   mchrm_pkg::flags_type flags_wd;
   logic        ws_we, cnt_we, lmt_we, cfg_we, def_we;
   logic [63:0] ws_wd;
   logic [31:0] cnt_wd;

   // Combinational helpers.
   logic        accept, okch, cfg_ok;
   logic [CW-1:0] cap_eff;
   logic [7:0]  ch_num;
   logic        emit_en;
   mchrm_pkg::event_type emit_ev;
   logic [63:0] anchor, silence;
   logic        dead_hit, rate_go, room;
   logic [71:0] prod;
   logic [63:0] lohy, hclr, lo64, hi64;
   logic        low_ev, high_ev;

   mchrm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_idx_full = req_channel - 8'd1;
   assign rd_idx = (state_ff == mchrm_pkg::ST_IDLE) ? req_idx_full[IW-1:0] : idx_ff;
   assign ch_num = 8'(idx_ff) + 8'd1;

   assign f      = flags_ff[rd_idx];
   assign lmt_rd = lmt_mem[rd_idx];
   assign ct_rd  = ct_mem[rd_idx];
   assign ws_rd  = ws_mem[rd_idx];
   assign cnt_rd = cnt_mem[rd_idx];
   assign to_rd  = to_mem[rd_idx];
   assign wl_rd  = wl_mem[rd_idx];
   assign lo_rd  = lo_mem[rd_idx];
   assign hi_rd  = hi_mem[rd_idx];
   assign hy_rd  = hy_mem[rd_idx];
   assign sev_rd = sev_mem[rd_idx];
   assign dst_rd = dst_mem[rd_idx];
   assign dtm_rd = dtm_mem[rd_idx];
   assign drt_rd = drt_mem[rd_idx];

   assign busy   = (state_ff != mchrm_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign okch   = (req_channel != 8'd0) && (req_channel <= 8'(mchrm_pkg::TOPICS));
   assign cfg_ok = okch && !(req_heartbeat_on && (req_dead_timeout_ns == 64'd0))
                   && !(req_rate_on && ((req_window_ns == 64'd0)
                                        || !(req_high_limit_mhz > req_low_limit_mhz)));
   assign cap_eff = (csr_cap_ff > CW'(mchrm_pkg::MAX_EVENTS)) ?
                    CW'(mchrm_pkg::MAX_EVENTS) : csr_cap_ff;
   assign room = n_ff < cap_ff;

   // Dead-channel test: silence measured from the last message, or from
   // configuration when no message has been seen.
   assign anchor   = f.seen ? lmt_rd : ct_rd;
   assign silence  = now_ff - anchor;
   assign dead_hit = f.hb && (now_ff >= anchor) && (silence >= to_rd) && !f.dead && room;
   assign rate_go  = f.rate_on && f.seen && (now_ff >= ws_rd) && ((now_ff - ws_rd) >= wl_rd);

   assign prod = {p1_ff, 32'd0} + {8'd0, p0_ff};
   assign lo64 = {24'd0, lo_rd};
   assign hi64 = {24'd0, hi_rd};
   assign lohy = lo64 + {24'd0, hy_rd};
   assign hclr = (hy_rd >= hi_rd) ? 64'd0 : {24'd0, hi_rd - hy_rd};

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      cap_in        = cap_ff;
      now_in        = now_ff;
      elapsed_in    = elapsed_ff;
      wstart_in     = wstart_ff;
      rate_in       = rate_ff;
      p0_in         = p0_ff;
      p1_in         = p1_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      out_in        = out_ff;
      out_valid_in  = 1'b0;
      out_last_in   = 1'b0;
      div_req       = '0;
      div_req.dividend_hi = prod[71:64];
      div_req.dividend_lo = prod[63:0];
      div_req.divisor     = elapsed_ff;
      flags_we = 1'b0;
      flags_wd = f;
      ws_we    = 1'b0;
      ws_wd    = now_ff;
      cnt_we   = 1'b0;
      cnt_wd   = '0;
      lmt_we   = 1'b0;
      cfg_we   = 1'b0;
      def_we   = 1'b0;
      emit_en  = 1'b0;
      emit_ev  = '0;
      g        = f;
      low_ev   = 1'b0;
      high_ev  = 1'b0;

      case (state_ff)
         mchrm_pkg::ST_IDLE: begin
            if (accept) begin
               case (mchrm_pkg::opcode_type'(req_opcode))
                  mchrm_pkg::OP_MESSAGE: begin
                     if (okch && f.conf) begin
                        ws_we    = !f.seen;
                        ws_wd    = req_time_ns;
                        flags_we = 1'b1;
                        flags_wd.seen = 1'b1;
                        flags_wd.dead = 1'b0;
                        lmt_we   = 1'b1;
                        cnt_we   = 1'b1;
                        cnt_wd   = (cnt_rd == 32'hFFFF_FFFF) ? cnt_rd : cnt_rd + 32'd1;
                     end
                  end
                  mchrm_pkg::OP_TICK: begin
                     if (cap_eff != '0) begin
                        state_in = mchrm_pkg::ST_REPLAY;
                        idx_in   = '0;
                        n_in     = '0;
                        cap_in   = cap_eff;
                        now_in   = req_time_ns;
                     end
                  end
                  mchrm_pkg::OP_CONFIGURE: begin
                     if (cfg_ok) begin
                        flags_we = 1'b1;
                        flags_wd = '0;
                        flags_wd.conf    = 1'b1;
                        flags_wd.hb      = req_heartbeat_on;
                        flags_wd.rate_on = req_rate_on;
                        cfg_we   = 1'b1;
                        ws_we    = 1'b1;
                        ws_wd    = req_time_ns;
                        cnt_we   = 1'b1;
                        cnt_wd   = '0;
                     end
                     out_valid_in = 1'b1;
                     out_last_in  = 1'b1;
                     out_in       = '0;
                     out_in.kind  = cfg_ok ? mchrm_pkg::KIND_ACCEPTED : mchrm_pkg::KIND_REJECTED;
                     out_in.channel = req_channel;
                  end
                  mchrm_pkg::OP_DECONFIGURE: begin
                     if (okch) begin
                        flags_we = 1'b1;
                        flags_wd = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Deferred rate events go out first, in channel order.
         mchrm_pkg::ST_REPLAY: begin
            if (f.conf && f.pend && !room) begin
               state_in = mchrm_pkg::ST_DONE;
            end else begin
               if (f.conf && f.pend) begin
                  emit_en = 1'b1;
                  emit_ev.kind = f.phigh ? mchrm_pkg::KIND_RATE_HIGH : mchrm_pkg::KIND_RATE_LOW;
                  emit_ev.severity   = sev_rd;
                  emit_ev.channel    = ch_num;
                  emit_ev.origin     = dst_rd;
                  emit_ev.event_time = dtm_rd;
                  emit_ev.measured   = drt_rd;
                  emit_ev.limit      = f.phigh ? hi64 : lo64;
                  flags_we = 1'b1;
                  flags_wd.pend  = 1'b0;
                  flags_wd.phigh = 1'b0;
               end
               if (idx_ff == IW'(mchrm_pkg::TOPICS - 1)) begin
                  state_in = mchrm_pkg::ST_SCAN;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         mchrm_pkg::ST_SCAN: begin
            if (f.conf) begin
               if (dead_hit) begin
                  emit_en = 1'b1;
                  emit_ev.kind       = mchrm_pkg::KIND_DEAD;
                  emit_ev.severity   = sev_rd;
                  emit_ev.channel    = ch_num;
                  emit_ev.origin     = anchor + to_rd;
                  emit_ev.event_time = now_ff;
                  emit_ev.measured   = silence;
                  emit_ev.limit      = to_rd;
                  flags_we = 1'b1;
                  flags_wd.dead = 1'b1;
               end
            end
            if (f.conf && rate_go) begin
               elapsed_in = now_ff - ws_rd;
               wstart_in  = ws_rd;
               state_in   = mchrm_pkg::ST_MUL;
            end else if (idx_ff == IW'(mchrm_pkg::TOPICS - 1)) begin
               state_in = mchrm_pkg::ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // count * 1e12 as two registered partial products.
         mchrm_pkg::ST_MUL: begin
            p0_in    = cnt_rd * mchrm_pkg::TERA_LO;
            p1_in    = 40'(cnt_rd * 40'(mchrm_pkg::TERA_HI));
            state_in = mchrm_pkg::ST_PROD;
         end

         mchrm_pkg::ST_PROD: begin
            if ({56'd0, prod[71:64]} >= elapsed_ff) begin
               rate_in  = 64'hFFFF_FFFF_FFFF_FFFF;
               state_in = mchrm_pkg::ST_EVAL;
            end else begin
               div_req.start = 1'b1;
               state_in      = mchrm_pkg::ST_DIV;
            end
         end

         mchrm_pkg::ST_DIV: begin
            if (div_done) begin
               rate_in  = div_q;
               state_in = mchrm_pkg::ST_EVAL;
            end
         end

         // Window end: hysteresis release first, then a new low or high crossing.
         mchrm_pkg::ST_EVAL: begin
            if (g.low && (rate_ff >= lohy)) g.low = 1'b0;
            if (g.high && (rate_ff <= hclr)) g.high = 1'b0;
            low_ev  = (rate_ff <= lo64) && !g.low;
            high_ev = !low_ev && (rate_ff >= hi64) && !g.high;
            if (low_ev || high_ev) begin
               if (room) begin
                  emit_en = 1'b1;
                  emit_ev.kind = high_ev ? mchrm_pkg::KIND_RATE_HIGH : mchrm_pkg::KIND_RATE_LOW;
                  emit_ev.severity   = sev_rd;
                  emit_ev.channel    = ch_num;
                  emit_ev.origin     = wstart_ff;
                  emit_ev.event_time = now_ff;
                  emit_ev.measured   = rate_ff;
                  emit_ev.limit      = high_ev ? hi64 : lo64;
               end else begin
                  g.pend  = 1'b1;
                  g.phigh = high_ev;
                  def_we  = 1'b1;
               end
               if (low_ev) g.low = 1'b1;
               if (high_ev) g.high = 1'b1;
            end
            flags_we = 1'b1;
            flags_wd = g;
            ws_we    = 1'b1;
            ws_wd    = now_ff;
            cnt_we   = 1'b1;
            cnt_wd   = '0;
            if (idx_ff == IW'(mchrm_pkg::TOPICS - 1)) begin
               state_in = mchrm_pkg::ST_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = mchrm_pkg::ST_SCAN;
            end
         end

         // The held event is the tick's final beat.
         mchrm_pkg::ST_DONE: begin
            out_valid_in  = held_valid_ff;
            out_last_in   = 1'b1;
            out_in        = held_ff;
            held_valid_in = 1'b0;
            state_in      = mchrm_pkg::ST_IDLE;
         end

         default: state_in = mchrm_pkg::ST_IDLE;
      endcase

      // A new event pushes the previously held one out as a non-final beat.
      if (emit_en) begin
         if (held_valid_ff) begin
            out_valid_in = 1'b1;
            out_last_in  = 1'b0;
            out_in       = held_ff;
         end
         held_in       = emit_ev;
         held_valid_in = 1'b1;
         n_in          = n_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mchrm_pkg::ST_IDLE;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         csr_cap_ff    <= CW'(mchrm_pkg::MAX_EVENTS);
      end else begin
         state_ff      <= state_in;
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
         if (csr_we) csr_cap_ff <= csr_wdata;
      end
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      cap_ff      <= cap_in;
      now_ff      <= now_in;
      elapsed_ff  <= elapsed_in;
      wstart_ff   <= wstart_in;
      rate_ff     <= rate_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      held_ff     <= held_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mchrm_pkg::TOPICS; i++) flags_ff[i] <= '0;
      end else if (flags_we) begin
         flags_ff[rd_idx] <= flags_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (ws_we) ws_mem[rd_idx] <= ws_wd;
      if (cnt_we) cnt_mem[rd_idx] <= cnt_wd;
      if (lmt_we) lmt_mem[rd_idx] <= req_time_ns;
      if (cfg_we) begin
         ct_mem[rd_idx]  <= req_time_ns;
         to_mem[rd_idx]  <= req_dead_timeout_ns;
         wl_mem[rd_idx]  <= req_window_ns;
         lo_mem[rd_idx]  <= req_low_limit_mhz;
         hi_mem[rd_idx]  <= req_high_limit_mhz;
         hy_mem[rd_idx]  <= req_hysteresis_mhz;
         sev_mem[rd_idx] <= req_severity;
      end
      if (def_we) begin
         dst_mem[rd_idx] <= wstart_ff;
         dtm_mem[rd_idx] <= now_ff;
         drt_mem[rd_idx] <= rate_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_event_severity = out_ff.severity;
   assign rsp_event_channel  = out_ff.channel;
   assign rsp_origin_ns      = out_ff.origin;
   assign rsp_event_time_ns  = out_ff.event_time;
   assign rsp_measured       = out_ff.measured;
   assign rsp_limit          = out_ff.limit;
   assign rsp_last           = out_last_ff;

endmodule

// ===== sv/mchrm_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle, for the rate monitor.
// Depends on mchrm_pkg. The caller guarantees the high dividend part is below the divisor.
module mchrm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  mchrm_pkg::div_req_type div_req,
   output logic                  done,
   output logic [63:0]           quotient
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] lo_ff, lo_in;
   logic [63:0] q_ff, q_in;
   logic [63:0] d_ff, d_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] shifted;
   logic        take;

   always_comb begin
      shifted = {rem_ff, lo_ff[63]};
      take    = shifted >= {1'b0, d_ff};
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = {56'd0, div_req.dividend_hi};
         lo_in   = div_req.dividend_lo;
         d_in    = div_req.divisor;
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take ? 64'(shifted - {1'b0, d_ff}) : shifted[63:0];
         lo_in  = {lo_ff[62:0], 1'b0};
         q_in   = {q_ff[62:0], take};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== sim/multi_channel_heartbeat_rate_monitor_tb.sv =====
// Self-checking testbench for multi_channel_heartbeat_rate_monitor.
// Depends on mchrm_pkg and the monitor RTL; it keeps its own model of the channel table and
// checks every result beat against it.
module multi_channel_heartbeat_rate_monitor_tb;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam logic [63:0] ONE_E12 = 64'd1000000000000;

   typedef struct {
      mchrm_pkg::opcode_type op;
      logic [7:0]  ch;
      logic [63:0] t;
      logic        hb;
      logic [63:0] to;
      logic        rt;
      logic [63:0] win;
      logic [39:0] lo;
      logic [39:0] hi;
      logic [39:0] hy;
      logic [7:0]  sev;
   } monitor_req_type;

   typedef struct {
      mchrm_pkg::kind_type kind;
      logic [7:0]  sev;
      logic [7:0]  ch;
      logic [63:0] first;
      logic [63:0] tm;
      logic [63:0] meas;
      logic [63:0] lim;
      logic        last;
   } monitor_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = '0;
   logic [7:0]  req_channel = '0;
   logic [63:0] req_time_ns = '0;
   logic        req_heartbeat_on = 1'b0;
   logic [63:0] req_dead_timeout_ns = '0;
   logic        req_rate_on = 1'b0;
   logic [63:0] req_window_ns = '0;
   logic [39:0] req_low_limit_mhz = '0;
   logic [39:0] req_high_limit_mhz = '0;
   logic [39:0] req_hysteresis_mhz = '0;
   logic [7:0]  req_severity = '0;
   logic        csr_we = 1'b0;
   logic [5:0]  csr_wdata = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_event_severity;
   logic [7:0]  rsp_event_channel;
   logic [63:0] rsp_origin_ns;
   logic [63:0] rsp_event_time_ns;
   logic [63:0] rsp_measured;
   logic [63:0] rsp_limit;
   logic        rsp_last;

   multi_channel_heartbeat_rate_monitor dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_channel(req_channel), .req_time_ns(req_time_ns),
      .req_heartbeat_on(req_heartbeat_on), .req_dead_timeout_ns(req_dead_timeout_ns),
      .req_rate_on(req_rate_on), .req_window_ns(req_window_ns),
      .req_low_limit_mhz(req_low_limit_mhz), .req_high_limit_mhz(req_high_limit_mhz),
      .req_hysteresis_mhz(req_hysteresis_mhz), .req_severity(req_severity),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_event_severity(rsp_event_severity),
      .rsp_event_channel(rsp_event_channel), .rsp_origin_ns(rsp_origin_ns),
      .rsp_event_time_ns(rsp_event_time_ns), .rsp_measured(rsp_measured),
      .rsp_limit(rsp_limit), .rsp_last(rsp_last)
   );

   always #6 clock = ~clock;

   // Our own copy of the channel table, indexed by channel number 1..TOPICS.
   mchrm_pkg::flags_type chan_flags [1:mchrm_pkg::TOPICS];
   logic [63:0] last_msg_ns [1:mchrm_pkg::TOPICS];
   logic [63:0] conf_ns [1:mchrm_pkg::TOPICS];
   logic [63:0] win_start_ns [1:mchrm_pkg::TOPICS];
   logic [31:0] win_count [1:mchrm_pkg::TOPICS];
   logic [63:0] timeout_ns [1:mchrm_pkg::TOPICS];
   logic [63:0] win_len_ns [1:mchrm_pkg::TOPICS];
   logic [39:0] low_lim [1:mchrm_pkg::TOPICS];
   logic [39:0] high_lim [1:mchrm_pkg::TOPICS];
   logic [39:0] hyst [1:mchrm_pkg::TOPICS];
   logic [7:0]  sev_code [1:mchrm_pkg::TOPICS];
   logic [63:0] held_start [1:mchrm_pkg::TOPICS];
   logic [63:0] held_time [1:mchrm_pkg::TOPICS];
   logic [63:0] held_rate [1:mchrm_pkg::TOPICS];
   logic [5:0]  capacity = 6'd32;

   monitor_event_type expected_events [$];
   int errors = 0;
   int beats_sent = 0;
   int events_seen = 0;
   int idle_pct = 0;
   int quiet_cycles = 0;
   logic [63:0] now_ns = 64'd0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      errors++;
      $display("ERROR at %0t: %s got %0h expected %0h", $time, what, got, want);
   endtask

   function automatic logic [63:0] rate_of(input logic [31:0] cnt, input logic [63:0] el);
      logic [127:0] prod;
      logic [127:0] quot;
      if (el == 64'd0) return 64'd0;
      prod = 128'(cnt) * 128'(ONE_E12);
      quot = prod / 128'(el);
      if (quot[127:64] != 64'd0) return '1;
      return quot[63:0];
   endfunction

   function automatic void clear_chan(input int c);
      chan_flags[c] = '0;
      last_msg_ns[c] = '0;
      conf_ns[c] = '0;
      win_start_ns[c] = '0;
      win_count[c] = '0;
      timeout_ns[c] = '0;
      win_len_ns[c] = '0;
      low_lim[c] = '0;
      high_lim[c] = '0;
      hyst[c] = '0;
      sev_code[c] = '0;
      held_start[c] = '0;
      held_time[c] = '0;
      held_rate[c] = '0;
   endfunction

   function automatic void push_event(input mchrm_pkg::kind_type k, input logic [7:0] sv,
                                      input logic [7:0] c, input logic [63:0] first,
                                      input logic [63:0] tm, input logic [63:0] meas,
                                      input logic [63:0] lim);
      monitor_event_type e;
      e.kind = k; e.sev = sv; e.ch = c; e.first = first; e.tm = tm;
      e.meas = meas; e.lim = lim; e.last = 1'b0;
      expected_events.push_back(e);
   endfunction

   // A tick: deferred rate events first, then the dead and window scan.
   function automatic void predict_tick(input logic [63:0] now);
      int cap;
      int n;
      bit full;
      mchrm_pkg::flags_type f;
      logic [63:0] ws, el, rate, lo, hi, hy, hclr, anchor;
      cap = (capacity > 6'd32) ? 32 : int'(capacity);
      n = 0;
      full = 0;
      if (cap == 0) return;
      for (int c = 1; c <= mchrm_pkg::TOPICS && !full; c++) begin
         f = chan_flags[c];
         if (f.conf && f.pend) begin
            if (n >= cap) begin
               full = 1;
            end else begin
               push_event(f.phigh ? mchrm_pkg::KIND_RATE_HIGH : mchrm_pkg::KIND_RATE_LOW,
                          sev_code[c], 8'(c), held_start[c], held_time[c], held_rate[c],
                          f.phigh ? 64'(high_lim[c]) : 64'(low_lim[c]));
               n++;
               chan_flags[c].pend = 1'b0;
               chan_flags[c].phigh = 1'b0;
            end
         end
      end
      for (int c = 1; c <= mchrm_pkg::TOPICS && !full; c++) begin
         f = chan_flags[c];
         if (!f.conf) continue;
         if (f.hb) begin
            anchor = f.seen ? last_msg_ns[c] : conf_ns[c];
            if (now >= anchor && now - anchor >= timeout_ns[c] && !f.dead && n < cap) begin
               push_event(mchrm_pkg::KIND_DEAD, sev_code[c], 8'(c), anchor + timeout_ns[c],
                          now, now - anchor, timeout_ns[c]);
               n++;
               f.dead = 1'b1;
            end
         end
         ws = win_start_ns[c];
         if (!f.rate_on || !f.seen || now < ws || now - ws < win_len_ns[c]) begin
            chan_flags[c] = f;
            continue;
         end
         el = now - ws;
         rate = rate_of(win_count[c], el);
         lo = 64'(low_lim[c]);
         hi = 64'(high_lim[c]);
         hy = 64'(hyst[c]);
         hclr = (hy >= hi) ? 64'd0 : hi - hy;
         if (f.low && rate >= lo + hy) f.low = 1'b0;
         if (f.high && rate <= hclr) f.high = 1'b0;
         if (rate <= lo && !f.low) begin
            if (n < cap) begin
               push_event(mchrm_pkg::KIND_RATE_LOW, sev_code[c], 8'(c), ws, now, rate, lo);
               n++;
            end else begin
               f.pend = 1'b1; f.phigh = 1'b0;
               held_start[c] = ws; held_time[c] = now; held_rate[c] = rate;
            end
            f.low = 1'b1;
         end else if (rate >= hi && !f.high) begin
            if (n < cap) begin
               push_event(mchrm_pkg::KIND_RATE_HIGH, sev_code[c], 8'(c), ws, now, rate, hi);
               n++;
            end else begin
               f.pend = 1'b1; f.phigh = 1'b1;
               held_start[c] = ws; held_time[c] = now; held_rate[c] = rate;
            end
            f.high = 1'b1;
         end
         win_start_ns[c] = now;
         win_count[c] = '0;
         chan_flags[c] = f;
      end
      if (n > 0) expected_events[$].last = 1'b1;
   endfunction

   function automatic void predict_beat(input monitor_req_type r);
      bit okch;
      bit ok;
      int c;
      okch = (r.ch >= 8'd1) && (r.ch <= 8'(mchrm_pkg::TOPICS));
      c = okch ? int'(r.ch) : 1;
      case (r.op)
         mchrm_pkg::OP_MESSAGE: begin
            if (okch && chan_flags[c].conf) begin
               if (!chan_flags[c].seen) win_start_ns[c] = r.t;
               chan_flags[c].seen = 1'b1;
               chan_flags[c].dead = 1'b0;
               last_msg_ns[c] = r.t;
               if (win_count[c] != '1) win_count[c]++;
            end
         end
         mchrm_pkg::OP_TICK: predict_tick(r.t);
         mchrm_pkg::OP_CONFIGURE: begin
            ok = okch;
            if (r.hb && r.to == 64'd0) ok = 0;
            if (r.rt && (r.win == 64'd0 || !(r.hi > r.lo))) ok = 0;
            if (ok) begin
               clear_chan(c);
               chan_flags[c].conf = 1'b1;
               chan_flags[c].hb = r.hb;
               chan_flags[c].rate_on = r.rt;
               conf_ns[c] = r.t;
               win_start_ns[c] = r.t;
               timeout_ns[c] = r.to;
               win_len_ns[c] = r.win;
               low_lim[c] = r.lo;
               high_lim[c] = r.hi;
               hyst[c] = r.hy;
               sev_code[c] = r.sev;
            end
            push_event(ok ? mchrm_pkg::KIND_ACCEPTED : mchrm_pkg::KIND_REJECTED, '0, r.ch,
                       '0, '0, '0, '0);
            expected_events[$].last = 1'b1;
         end
         mchrm_pkg::OP_DECONFIGURE: if (okch) clear_chan(c);
         default: ;
      endcase
   endfunction

   // Check every result beat against the oldest expectation.
   always @(posedge clock) begin
      monitor_event_type e;
      if (!reset && rsp_valid) begin
         events_seen++;
         if (expected_events.size() == 0) begin
            report("result with nothing expected, kind", 64'(rsp_kind), 64'd0);
         end else begin
            e = expected_events.pop_front();
            if (rsp_kind !== e.kind) report("kind", 64'(rsp_kind), 64'(e.kind));
            if (rsp_event_severity !== e.sev)
               report("severity", 64'(rsp_event_severity), 64'(e.sev));
            if (rsp_event_channel !== e.ch)
               report("channel", 64'(rsp_event_channel), 64'(e.ch));
            if (rsp_origin_ns !== e.first) report("origin", rsp_origin_ns, e.first);
            if (rsp_event_time_ns !== e.tm) report("event_time", rsp_event_time_ns, e.tm);
            if (rsp_measured !== e.meas) report("measured", rsp_measured, e.meas);
            if (rsp_limit !== e.lim) report("limit", rsp_limit, e.lim);
            if (rsp_last !== e.last) report("last", 64'(rsp_last), 64'(e.last));
         end
      end
   end

   // Watchdog on cycles with neither an accepted beat nor a result.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: %0d beats still expected", expected_events.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_beat(input monitor_req_type r);
      req_opcode = r.op;
      req_channel = r.ch;
      req_time_ns = r.t;
      req_heartbeat_on = r.hb;
      req_dead_timeout_ns = r.to;
      req_rate_on = r.rt;
      req_window_ns = r.win;
      req_low_limit_mhz = r.lo;
      req_high_limit_mhz = r.hi;
      req_hysteresis_mhz = r.hy;
      req_severity = r.sev;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_beat(r);
      beats_sent++;
      @(negedge clock);
      start = 1'b0;
      // Each cycle the sender stays idle with the chosen probability.
      while ($urandom_range(99) < idle_pct) @(negedge clock);
   endtask

   function automatic monitor_req_type msg_req(input logic [7:0] ch, input logic [63:0] t);
      monitor_req_type r;
      r = '{op: mchrm_pkg::OP_MESSAGE, ch: ch, t: t, hb: 0, to: 0, rt: 0, win: 0, lo: 0,
            hi: 0, hy: 0, sev: 0};
      return r;
   endfunction

   function automatic monitor_req_type tick_req(input logic [63:0] t);
      monitor_req_type r;
      r = msg_req(8'd0, t);
      r.op = mchrm_pkg::OP_TICK;
      return r;
   endfunction

   function automatic monitor_req_type cfg_req(input logic [7:0] ch, input logic [63:0] t,
                                               input logic hb, input logic [63:0] to,
                                               input logic rt, input logic [63:0] win,
                                               input logic [39:0] lo, input logic [39:0] hi,
                                               input logic [39:0] hy, input logic [7:0] sev);
      monitor_req_type r;
      r = '{op: mchrm_pkg::OP_CONFIGURE, ch: ch, t: t, hb: hb, to: to, rt: rt, win: win,
            lo: lo, hi: hi, hy: hy, sev: sev};
      return r;
   endfunction

   function automatic monitor_req_type rand_cfg(input logic [7:0] ch, input logic [63:0] t);
      logic [39:0] lo;
      lo = 40'($urandom_range(1, 40)) * 40'd100000000;
      return cfg_req(ch, t, 1'($urandom_range(1)), 64'($urandom_range(200, 3000)),
                     $urandom_range(3) != 0, 64'($urandom_range(300, 2000)), lo,
                     lo + 40'($urandom_range(1, 40)) * 40'd100000000,
                     40'($urandom_range(0, 30)) * 40'd100000000, 8'($urandom_range(255)));
   endfunction

   // Wait until the block is idle and no results are still expected.
   task automatic wait_idle();
      while (expected_events.size() != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_capacity(input logic [5:0] v);
      wait_idle();
      csr_wdata = v;
      csr_we = 1'b1;
      @(negedge clock);
      csr_we = 1'b0;
      capacity = v;
   endtask

   // Bad channels, invalid settings, backwards time, capacity corners and field extremes.
   task automatic test_directed();
      monitor_req_type r;
      set_capacity(6'd63);
      send_beat(cfg_req(8'd0, 64'd10, 1, 64'd5, 0, 0, 0, 0, 0, 8'd1));
      send_beat(cfg_req(8'd255, '1, 1, '1, 1, '1, 40'd5, '1, '1, 8'd255));
      send_beat(cfg_req(8'd1, 64'd20, 1, 64'd0, 0, 64'd1, 0, 0, 0, 8'd2));
      send_beat(cfg_req(8'd2, 64'd20, 0, 64'd0, 1, 64'd0, 40'd1, 40'd2, 0, 8'd3));
      send_beat(cfg_req(8'd2, 64'd20, 0, 64'd0, 1, 64'd100, 40'd9, 40'd9, 0, 8'd3));
      send_beat(msg_req(8'd5, 64'd30));
      send_beat(cfg_req(8'd1, 64'd1000, 1, 64'd100, 0, 64'd0, 0, 0, 0, 8'd255));
      // Hysteresis above the high limit: the clear threshold floors at zero.
      send_beat(cfg_req(8'd2, 64'd1000, 1, '1, 1, 64'd1000, 40'd1000000000,
                        40'd5000000000, 40'd6000000000, 8'd7));
      send_beat(cfg_req(8'd16, 64'd1000, 0, 64'd0, 1, 64'd500, 40'd2000000000,
                        40'd3000000000, 40'd100000000, 8'd128));
      send_beat(msg_req(8'd2, 64'd1100));
      for (int k = 0; k < 4; k++) send_beat(msg_req(8'd16, 64'd1200 + 64'(k)));
      send_beat(tick_req(64'd2000));
      send_beat(tick_req(64'd1500));
      send_beat(msg_req(8'd0, 64'd2100));
      r = msg_req(8'd16, 64'd0);
      r.op = mchrm_pkg::OP_DECONFIGURE;
      send_beat(r);
      r.ch = 8'd0;
      send_beat(r);
      set_capacity(6'd0);
      send_beat(tick_req(64'd9000));
      // One slot per tick with several windows ending: a rate event is deferred.
      set_capacity(6'd1);
      send_beat(cfg_req(8'd3, 64'd3000, 0, 0, 1, 64'd200, 40'd1, '1, 0, 8'd30));
      send_beat(cfg_req(8'd4, 64'd3000, 0, 0, 1, 64'd200, 40'd1, '1, 0, 8'd40));
      send_beat(msg_req(8'd3, 64'd3010));
      send_beat(msg_req(8'd4, 64'd3010));
      send_beat(tick_req(64'd4000));
      send_beat(tick_req(64'd4001));
      send_beat(tick_req('1));
   endtask

   // Random traffic on freshly configured channels, with some bad channels and random raw beats.
   task automatic test_random_traffic(input int n_items, input int idle, input logic [5:0] cap);
      monitor_req_type r;
      int pick;
      set_capacity(cap);
      idle_pct = idle;
      for (int c = 1; c <= mchrm_pkg::TOPICS; c++) begin
         now_ns += 64'($urandom_range(1, 20));
         send_beat(rand_cfg(8'(c), now_ns));
      end
      for (int k = 0; k < n_items; k++) begin
         now_ns += 64'($urandom_range(1, 150));
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_beat(msg_req($urandom_range(19) == 0 ? 8'($urandom_range(255))
                              : 8'($urandom_range(1, mchrm_pkg::TOPICS)), now_ns));
         end else if (pick < 75) begin
            send_beat(tick_req(now_ns));
         end else if (pick < 85) begin
            send_beat(rand_cfg(8'($urandom_range(1, mchrm_pkg::TOPICS)), now_ns));
         end else if (pick < 89) begin
            r = msg_req(8'($urandom_range(1, mchrm_pkg::TOPICS)), now_ns);
            r.op = mchrm_pkg::OP_DECONFIGURE;
            send_beat(r);
         end else begin
            r = '{op: mchrm_pkg::opcode_type'($urandom_range(3)), ch: 8'($urandom_range(255)),
                  t: {$urandom, $urandom}, hb: 1'($urandom_range(1)),
                  to: {$urandom, $urandom}, rt: 1'($urandom_range(1)),
                  win: {$urandom, $urandom}, lo: 40'({$urandom, $urandom}),
                  hi: 40'({$urandom, $urandom}), hy: 40'({$urandom, $urandom}),
                  sev: 8'($urandom_range(255))};
            send_beat(r);
         end
      end
   endtask

   initial begin
      for (int c = 1; c <= mchrm_pkg::TOPICS; c++) clear_chan(c);
      repeat (11) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_traffic(50, 24, 6'd2);
      test_random_traffic(50, 59, 6'd63);
      test_random_traffic(50, 0, 6'd32);
      wait_idle();
      repeat (20) @(negedge clock);
      $display("Covered %0d beats in and %0d result beats out, capacities 0 to 63.",
               beats_sent, events_seen);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", errors);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== multi_channel_heartbeat_rate_monitor.f =====
sv/mchrm_pkg.sv
sv/mchrm_div.sv
sv/multi_channel_heartbeat_rate_monitor.sv
sim/multi_channel_heartbeat_rate_monitor_tb.sv
